// File: sv/nsq_pkg.sv
// Shared types and constants for the nearest-scale int8 quantizer.
`default_nettype none
package nsq_pkg;

    localparam int OUT_WIDTH  = 96;
    localparam int OUT_HEIGHT = 96;
    localparam int SRC_MAX    = 2048;

    localparam int SIZE_W = 12;   // size registers
    localparam int POS_W  = 11;   // source column / row counters
    localparam int SUM_W  = 18;   // scaled sums, up to OUT_* * SRC_MAX
    localparam int IDX_W  = 7;    // output column / row

    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_QUANT_GAIN    = 2'd2,
        REG_ZERO_OFFSET   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } src_beat_t;

    typedef struct packed {
        logic signed [7:0] value;
        logic [6:0]        out_col;
        logic [6:0]        out_row;
        logic              frame_last;
    } res_beat_t;

    typedef struct packed {
        logic [SIZE_W-1:0] source_width;
        logic [SIZE_W-1:0] source_height;
        logic [23:0]       quant_gain;
        logic signed [7:0] zero_offset;
    } cfg_t;

    // Selected pixel on its way to the quantizer
    typedef struct packed {
        logic [7:0]       pixel;
        logic [IDX_W-1:0] out_col;
        logic [IDX_W-1:0] out_row;
        logic             frame_last;
    } sel_beat_t;

endpackage
`default_nettype wire

// File: sv/nsq_cfg.sv
// APB configuration registers of the quantizer.
`default_nettype none
module nsq_cfg
    import nsq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= 12'd160;
            cfg_reg.source_height <= 12'd120;
            cfg_reg.quant_gain    <= 24'd65536;
            cfg_reg.zero_offset   <= -8'sd128;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= pwdata[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= pwdata[SIZE_W-1:0];
                REG_QUANT_GAIN:    cfg_reg.quant_gain    <= pwdata[23:0];
                REG_ZERO_OFFSET:   cfg_reg.zero_offset   <= $signed(pwdata[7:0]);
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SOURCE_WIDTH:  prdata = {20'd0, cfg_reg.source_width};
            REG_SOURCE_HEIGHT: prdata = {20'd0, cfg_reg.source_height};
            REG_QUANT_GAIN:    prdata = {8'd0, cfg_reg.quant_gain};
            REG_ZERO_OFFSET:   prdata = {24'd0, cfg_reg.zero_offset};
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/nsq_scan.sv
// Raster counters and nearest-neighbor pixel selection.
`default_nettype none
module nsq_scan
    import nsq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      src_valid,
    output logic           src_ready,
    input  wire src_beat_t src_data,
    output logic           sel_valid,
    input  wire logic      sel_ready,
    output sel_beat_t      sel_data
);

    localparam logic [SUM_W-1:0]  OUT_W_SUM  = SUM_W'(OUT_WIDTH);
    localparam logic [SUM_W-1:0]  OUT_H_SUM  = SUM_W'(OUT_HEIGHT);
    localparam logic [IDX_W-1:0]  OUT_W_IDX  = IDX_W'(OUT_WIDTH);
    localparam logic [IDX_W-1:0]  OUT_H_IDX  = IDX_W'(OUT_HEIGHT);
    localparam logic [SIZE_W-1:0] SRC_MAX_SZ = SIZE_W'(SRC_MAX);

    function automatic logic [SIZE_W-1:0] eff_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] lo
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < lo)
            r = lo;
        else if (v > SRC_MAX_SZ)
            r = SRC_MAX_SZ;
        return r;
    endfunction

    // pos*outs <= sum < pos*outs + outs
    function automatic logic is_target(
        input logic [POS_W-1:0] pos,
        input logic [SUM_W-1:0] sum,
        input logic [SUM_W-1:0] outs
    );
        logic [SUM_W-1:0] lo;
        lo = SUM_W'(pos) * outs;
        return (sum >= lo) && (sum < lo + outs);
    endfunction

    logic [POS_W-1:0] src_col_reg, src_col_next;
    logic [POS_W-1:0] src_row_reg, src_row_next;
    logic [IDX_W-1:0] nout_col_reg, nout_col_next;
    logic [IDX_W-1:0] nout_row_reg, nout_row_next;
    logic [SUM_W-1:0] col_sum_reg, col_sum_next;
    logic [SUM_W-1:0] row_sum_reg, row_sum_next;

    logic             sel_valid_reg;
    sel_beat_t        sel_data_reg;

    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0]  c, r;
    logic [IDX_W-1:0]  oc, orow;
    logic [SUM_W-1:0]  cs, rs;
    logic              row_hit, hit, accept;

    assign w_eff     = eff_size(cfg.source_width,  SIZE_W'(OUT_WIDTH));
    assign h_eff     = eff_size(cfg.source_height, SIZE_W'(OUT_HEIGHT));
    assign src_ready = !sel_valid_reg || sel_ready;
    assign accept    = src_valid && src_ready;
    assign sel_valid = sel_valid_reg;
    assign sel_data  = sel_data_reg;

    always_comb
    begin
        // frame start clears the counters before this beat is handled
        c    = src_data.frame_start ? '0 : src_col_reg;
        r    = src_data.frame_start ? '0 : src_row_reg;
        oc   = src_data.frame_start ? '0 : nout_col_reg;
        orow = src_data.frame_start ? '0 : nout_row_reg;
        cs   = src_data.frame_start ? '0 : col_sum_reg;
        rs   = src_data.frame_start ? '0 : row_sum_reg;

        src_col_next  = c;
        src_row_next  = r;
        nout_col_next = oc;
        nout_row_next = orow;
        col_sum_next  = cs;
        row_sum_next  = rs;

        row_hit = 1'b0;
        hit     = 1'b0;

        // past the last output row the rest of the frame is dropped
        if (orow < OUT_H_IDX)
        begin
            row_hit = is_target(r, rs, OUT_H_SUM);
            hit     = row_hit && (oc < OUT_W_IDX) && is_target(c, cs, OUT_W_SUM);

            if (hit)
            begin
                nout_col_next = oc + 1'b1;
                col_sum_next  = cs + SUM_W'(w_eff);
            end

            if ({1'b0, c} + 1'b1 >= w_eff)
            begin
                src_col_next  = '0;
                src_row_next  = r + 1'b1;
                nout_col_next = '0;
                col_sum_next  = '0;
                if (row_hit)
                begin
                    nout_row_next = orow + 1'b1;
                    row_sum_next  = rs + SUM_W'(h_eff);
                end
            end
            else
            begin
                src_col_next = c + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            nout_col_reg  <= '0;
            nout_row_reg  <= '0;
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                src_col_reg  <= src_col_next;
                src_row_reg  <= src_row_next;
                nout_col_reg <= nout_col_next;
                nout_row_reg <= nout_row_next;
                col_sum_reg  <= col_sum_next;
                row_sum_reg  <= row_sum_next;
            end
            if (src_ready)
                sel_valid_reg <= accept && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            sel_data_reg.pixel      <= src_data.pixel;
            sel_data_reg.out_col    <= oc;
            sel_data_reg.out_row    <= orow;
            sel_data_reg.frame_last <= (oc == OUT_W_IDX - 1'b1) && (orow == OUT_H_IDX - 1'b1);
        end
    end

endmodule
`default_nettype wire

// File: sv/nsq_quant.sv
// Gain multiply, zero point add and int8 clamp, with the result register.
`default_nettype none
module nsq_quant
    import nsq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      sel_valid,
    output logic           sel_ready,
    input  wire sel_beat_t sel_data,
    output logic           res_valid,
    input  wire logic      res_ready,
    output res_beat_t      res_data
);

    logic              res_valid_reg;
    res_beat_t         res_data_reg;

    logic [31:0]        prod;
    logic signed [17:0] sum;
    logic signed [7:0]  clamped;

    assign sel_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        prod = 32'(sel_data.pixel) * 32'(cfg.quant_gain);
        sum  = $signed({2'b00, prod[31:16]}) + 18'(cfg.zero_offset);
        if (sum > 18'sd127)
            clamped = 8'sd127;
        else if (sum < -18'sd128)
            clamped = -8'sd128;
        else
            clamped = sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (sel_ready)
            res_valid_reg <= sel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sel_valid && sel_ready)
        begin
            res_data_reg.value      <= clamped;
            res_data_reg.out_col    <= sel_data.out_col;
            res_data_reg.out_row    <= sel_data.out_row;
            res_data_reg.frame_last <= sel_data.frame_last;
        end
    end

endmodule
`default_nettype wire

// File: sv/nearest_scale_int8_quantizer.sv
// Path: a selected pixel is registered in the scan stage, then in the quantize stage.
// Throughput: one src beat per cycle; a stalled result holds the quantize stage, and
//   src_ready drops only once the next selected beat also waits in the scan stage.
// Source beats that hit no output position are consumed with no result.
// Reset: asynchronous active-low rst_n clears the counters and valid flags and
//   loads the registers with 160x120, gain 1.0 and zero point -128.
`default_nettype none
module nearest_scale_int8_quantizer
    import nsq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  src_valid,
    output logic                       src_ready,
    input  wire src_beat_t             src_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_beat_t                  res_data
);

    cfg_t      cfg;
    logic      sel_valid;
    logic      sel_ready;
    sel_beat_t sel_data;

    nsq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nsq_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .sel_valid (sel_valid),
        .sel_ready (sel_ready),
        .sel_data  (sel_data)
    );

    nsq_quant u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sel_valid (sel_valid),
        .sel_ready (sel_ready),
        .sel_data  (sel_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire

// File: dv/nsq_checker.sv
`timescale 1ns / 1ps
// Checker: tracks register writes, predicts downscaled int8 samples and compares result beats.
module nsq_checker
    import nsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  src_valid,
    input  logic                  src_ready,
    input  src_beat_t             src_data,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  res_beat_t             res_data,
    output int                    pending,
    output int                    fail_count
);

    logic [SIZE_W-1:0] cfg_width;
    logic [SIZE_W-1:0] cfg_height;
    logic [23:0]       cfg_gain;
    logic signed [7:0] cfg_zero;

    // scan position and the output position being waited for
    int unsigned px_col;
    int unsigned px_row;
    int unsigned want_col;
    int unsigned want_row;
    int unsigned col_acc;
    int unsigned row_acc;

    res_beat_t samples_due[$];

    function automatic int unsigned clip_size(input logic [SIZE_W-1:0] v, input int unsigned lo);
        if (v < lo)
            return lo;
        if (v > SRC_MAX)
            return SRC_MAX;
        return 32'(v);
    endfunction

    function automatic bit on_grid(input int unsigned pos, input int unsigned acc,
                                   input int unsigned step);
        int unsigned lo;
        lo = pos * step;
        return (acc >= lo) && (acc < lo + step);
    endfunction

    function automatic logic signed [7:0] to_int8(input logic [7:0] pix);
        longint unsigned prod;
        longint          q;
        prod = longint'(pix) * longint'(cfg_gain);
        q = longint'(prod >> 16) + longint'(cfg_zero);
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[7:0];
    endfunction

    task automatic step_source(input src_beat_t b);
        int unsigned w;
        int unsigned h;
        bit          row_on;
        res_beat_t   r;
        w = clip_size(cfg_width, OUT_WIDTH);
        h = clip_size(cfg_height, OUT_HEIGHT);
        if (b.frame_start) begin
            px_col   = 0;
            px_row   = 0;
            want_col = 0;
            want_row = 0;
            col_acc  = 0;
            row_acc  = 0;
        end
        // frame done: everything until the next frame start is dropped
        if (want_row >= OUT_HEIGHT)
            return;
        row_on = on_grid(px_row, row_acc, OUT_HEIGHT);
        if (row_on && want_col < OUT_WIDTH && on_grid(px_col, col_acc, OUT_WIDTH)) begin
            r.value      = to_int8(b.pixel);
            r.out_col    = want_col[6:0];
            r.out_row    = want_row[6:0];
            r.frame_last = (want_col == OUT_WIDTH - 1) && (want_row == OUT_HEIGHT - 1);
            samples_due.push_back(r);
            want_col++;
            col_acc += w;
        end
        if (px_col + 1 >= w) begin
            px_col = 0;
            px_row = (px_row + 1) & 32'h7FF;
            if (row_on) begin
                want_row++;
                row_acc += h;
            end
            want_col = 0;
            col_acc  = 0;
        end
        else
        begin
            px_col++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_beat_t due;
        if (!rst_n) begin
            cfg_width  = 12'd160;
            cfg_height = 12'd120;
            cfg_gain   = 24'd65536;
            cfg_zero   = -8'sd128;
            px_col     = 0;
            px_row     = 0;
            want_col   = 0;
            want_row   = 0;
            col_acc    = 0;
            row_acc    = 0;
            samples_due.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SOURCE_WIDTH:  cfg_width  = pwdata[SIZE_W-1:0];
                    REG_SOURCE_HEIGHT: cfg_height = pwdata[SIZE_W-1:0];
                    REG_QUANT_GAIN:    cfg_gain   = pwdata[23:0];
                    REG_ZERO_OFFSET:   cfg_zero   = pwdata[7:0];
                    default: ;
                endcase
            end
            if (src_valid && src_ready)
                step_source(src_data);
            if (res_valid && res_ready) begin
                if (samples_due.size() == 0) begin
                    $error("unexpected result beat: value %0d col %0d row %0d last %0d",
                           res_data.value, res_data.out_col, res_data.out_row,
                           res_data.frame_last);
                    fail_count++;
                end
                else
                begin
                    due = samples_due.pop_front();
                    if (res_data.value !== due.value) begin
                        $error("value: expected %0d, got %0d", due.value, res_data.value);
                        fail_count++;
                    end
                    if (res_data.out_col !== due.out_col) begin
                        $error("out_col: expected %0d, got %0d", due.out_col, res_data.out_col);
                        fail_count++;
                    end
                    if (res_data.out_row !== due.out_row) begin
                        $error("out_row: expected %0d, got %0d", due.out_row, res_data.out_row);
                        fail_count++;
                    end
                    if (res_data.frame_last !== due.frame_last) begin
                        $error("frame_last: expected %0d, got %0d", due.frame_last,
                               res_data.frame_last);
                        fail_count++;
                    end
                end
            end
            pending = samples_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, pixel and register stimulus, and the final verdict.
module tb_top;
    import nsq_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  src_valid;
    logic                  src_ready;
    src_beat_t             src_data;
    logic                  res_valid;
    logic                  res_ready;
    res_beat_t             res_data;

    logic calm;     // no idle cycles on either side while set
    int   pending;
    int   fail_count;
    int   rand_items;
    int   phase;
    int   n;

    nearest_scale_int8_quantizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    nsq_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_data   (src_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        res_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 14) begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= '{pixel: pix, frame_start: fs};
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_regs(input logic [11:0] w, input logic [11:0] h,
                             input logic [23:0] g, input logic [7:0] z);
        write_reg(REG_SOURCE_WIDTH, {20'd0, w});
        write_reg(REG_SOURCE_HEIGHT, {20'd0, h});
        write_reg(REG_QUANT_GAIN, {8'd0, g});
        write_reg(REG_ZERO_OFFSET, {{24{z[7]}}, z});
    endtask

    // drop valid, wait out every expected beat plus the pipeline depth
    task automatic settle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_frame(input int count, input logic fs_first, input bit noisy);
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom_range(0, 255)),
                       (i == 0) ? fs_first : (noisy && $urandom_range(0, 49) == 0));
    endtask

    function automatic logic [11:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 12'd96;
            1:       return 12'd2048;
            2:       return 12'($urandom_range(0, 95));
            3:       return 12'($urandom_range(2049, 4095));
            default: return 12'($urandom_range(96, 200));
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 24'hFFFFFF));
            default: return 24'($urandom_range(200, 80000));
        endcase
    endfunction

    initial
    begin
        calm      = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        src_valid = 1'b0;
        src_data  = '0;
        res_ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // counters straight out of reset stand in for a frame start
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd1, 1'b0);
        settle();

        // undersized width, oversized height, top gain saturates high
        load_regs(12'd0, 12'd4095, 24'hFFFFFF, 8'h7F);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b1);
        send_pixel(8'd2, 1'b0);
        settle();

        // zero gain with the lowest zero point pins at -128
        load_regs(12'd2049, 12'd95, 24'd0, 8'h80);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd7, 1'b0);
        settle();

        load_regs(12'd2048, 12'd2048, 24'd256, 8'h00);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd128, 1'b0);
        settle();

        phase      = 0;
        rand_items = 0;
        while (rand_items < 800) begin
            calm <= (phase == 1);
            load_regs(pick_size(), pick_size(), pick_gain(), 8'($urandom_range(0, 255)));
            n = $urandom_range(60, 200);
            // sometimes carry on mid-frame under the new settings
            send_frame(n, $urandom_range(0, 3) != 0, 1'b1);
            rand_items += n;
            settle();
            phase++;
        end

        calm <= 1'b1;
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
